// File: hw/rtl/pce_pkg.sv
// shared types, codes and the nibble encoding function of the packetized encoder
package pce_pkg;

  // register map
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [1:0] REG_GEN_A = 2'd0;
  localparam logic [1:0] REG_GEN_B = 2'd1;
  localparam logic [1:0] REG_PACKET_NIBBLES = 2'd2;
  localparam logic [1:0] REG_IMAGE_BYTES = 2'd3;

  // marker bytes
  localparam logic [7:0] HEADER_BYTE = 8'h00;
  localparam logic [7:0] END_BYTE = 8'h01;

  // result kind on the output channel
  typedef enum logic [1:0] {
    KIND_ENC = 2'd0,
    KIND_HDR = 2'd1,
    KIND_END = 2'd2
  } kind_e;

  // packetizer phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_ENCODE = 2'd1,
    PH_FREE   = 2'd2
  } phase_e;

  // what goes out ahead of (or instead of) a nibble
  typedef enum logic [1:0] {
    PRE_NONE = 2'd0,
    PRE_HDR  = 2'd1,
    PRE_END  = 2'd2
  } pre_e;

  // one classified nibble between front and back
  typedef struct packed {
    pre_e       pre;
    logic [3:0] nib;
    logic       last;
  } job_t;

  // configuration register contents
  typedef struct packed {
    logic [2:0]  gen_a;
    logic [2:0]  gen_b;
    logic [15:0] packet_nibbles;
    logic [23:0] image_bytes;
  } cfg_t;

  // rate 1/2, constraint 3 code of one nibble, msb first, from zero state
  function automatic logic [7:0] conv_encode(input logic [3:0] nib, input logic [2:0] ga,
                                             input logic [2:0] gb);
    logic [1:0] sr;
    logic [2:0] win;
    logic [7:0] word;
    sr = '0;
    word = '0;
    win = '0;
    for (int k = 3; k >= 0; k--) begin
      win = {nib[k], sr};
      word = {word[5:0], ^(win & ga), ^(win & gb)};
      sr = win[2:1];
    end
    return word;
  endfunction

endpackage

// File: hw/rtl/pce_regs.sv
// configuration register file behind the apb-style port
module pce_regs import pce_pkg::*; #(
  parameter int unsigned IMAGE_COUNT_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  // image size keeps only the bits the counter can reach
  localparam logic [23:0] IMG_KEEP = (IMAGE_COUNT_BITS >= 24) ? 24'hFFFFFF :
                                     24'((64'd1 << IMAGE_COUNT_BITS) - 64'd1);

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (paddr[3:2])
        REG_GEN_A:          cfg_d.gen_a = pwdata[2:0];
        REG_GEN_B:          cfg_d.gen_b = pwdata[2:0];
        REG_PACKET_NIBBLES: cfg_d.packet_nibbles = pwdata[15:0];
        REG_IMAGE_BYTES:    cfg_d.image_bytes = pwdata[23:0] & IMG_KEEP;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gen_a <= 3'd7;
      cfg_q.gen_b <= 3'd5;
      cfg_q.packet_nibbles <= 16'd64;
      cfg_q.image_bytes <= 24'd1024 & IMG_KEEP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    unique case (paddr[3:2])
      REG_GEN_A:          prdata = {29'd0, cfg_q.gen_a};
      REG_GEN_B:          prdata = {29'd0, cfg_q.gen_b};
      REG_PACKET_NIBBLES: prdata = {16'd0, cfg_q.packet_nibbles};
      REG_IMAGE_BYTES:    prdata = {8'd0, cfg_q.image_bytes};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/pce_front.sv
// front end: accepts bytes, tracks packet and image counts, classifies each nibble
module pce_front import pce_pkg::*; #(
  parameter int unsigned PACKET_COUNT_BITS = 16,
  parameter int unsigned IMAGE_COUNT_BITS  = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  cfg_t       cfg_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output job_t       q_job_o
);

  localparam int unsigned CNT_W = IMAGE_COUNT_BITS + 1;
  localparam int unsigned CMP_W = (CNT_W > 25) ? CNT_W : 25;
  localparam int unsigned FCMP_W = (PACKET_COUNT_BITS > 16) ? PACKET_COUNT_BITS : 16;

  phase_e                       phase_q, phase_d;
  logic                         pend_q, pend_d;
  logic [3:0]                   hi_nib_q, hi_nib_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [PACKET_COUNT_BITS-1:0] fill_q, fill_d, fill_inc;
  logic                         step, under, wrap;
  logic [3:0]                   nib;

  // high nibble of a held byte goes after its low nibble, as soon as the queue has room
  assign in_stall_o = pend_q | q_full_i;
  assign step = !q_full_i & (pend_q | in_valid_i);
  assign nib = pend_q ? hi_nib_q : data_byte_i[3:0];

  // end test and packet wrap
  assign under = CMP_W'(cnt_q) < CMP_W'({cfg_i.image_bytes, 1'b0});
  assign fill_inc = fill_q + 1'b1;
  assign wrap = FCMP_W'(fill_inc) == FCMP_W'(cfg_i.packet_nibbles);

  // next state and queue push
  always_comb begin
    phase_d = phase_q;
    pend_d = pend_q;
    hi_nib_d = hi_nib_q;
    cnt_d = cnt_q;
    fill_d = fill_q;
    q_push_o = 1'b0;
    q_job_o.pre = PRE_NONE;
    q_job_o.nib = nib;
    q_job_o.last = pend_q;
    if (step) begin
      if (!pend_q) begin
        hi_nib_d = data_byte_i[7:4];
      end
      unique case (phase_q)
        PH_FREE: begin
          pend_d = 1'b0;
        end
        PH_HEADER, PH_ENCODE: begin
          if (phase_q == PH_HEADER && !under) begin
            q_push_o = 1'b1;
            q_job_o.pre = PRE_END;
            q_job_o.last = 1'b1;
            phase_d = PH_FREE;
            pend_d = 1'b0;
          end else begin
            q_push_o = 1'b1;
            q_job_o.pre = (phase_q == PH_HEADER) ? PRE_HDR : PRE_NONE;
            if (cnt_q != '1) begin
              cnt_d = cnt_q + 1'b1;
            end
            fill_d = wrap ? '0 : fill_inc;
            phase_d = wrap ? PH_HEADER : PH_ENCODE;
            pend_d = !pend_q;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pend_q <= 1'b0;
      cnt_q <= '0;
      fill_q <= '0;
    end else begin
      phase_q <= phase_d;
      pend_q <= pend_d;
      cnt_q <= cnt_d;
      fill_q <= fill_d;
    end
  end

  // held high nibble
  always_ff @(posedge clk_i) begin
    hi_nib_q <= hi_nib_d;
  end

endmodule

// File: hw/rtl/pce_queue.sv
// short job queue between front and back
module pce_queue import pce_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o,
  input  logic pop_i
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;
  logic             do_push, do_pop;

  assign full_o = count_q == (PTR_W + 1)'(DEPTH);
  assign valid_o = count_q != '0;
  assign job_o = mem_q[rd_ptr_q];
  assign do_push = push_i & !full_o;
  assign do_pop = pop_i & valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: hw/rtl/pce_back.sv
// back end: expands jobs into header, end and code beats in the output register
module pce_back import pce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  job_t       q_job_i,
  output logic       q_pop_o,
  input  cfg_t       cfg_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_o
);

  logic       valid_q, valid_d;
  logic       hdr_done_q, hdr_done_d;
  logic [7:0] byte_q, byte_d;
  kind_e      kind_q, kind_d;
  logic       last_q, last_d;
  logic       load;

  assign load = q_valid_i & (!valid_q | !out_stall_i);

  // pick the next beat of the head job
  always_comb begin
    valid_d = valid_q & out_stall_i;
    hdr_done_d = hdr_done_q;
    byte_d = byte_q;
    kind_d = kind_q;
    last_d = last_q;
    q_pop_o = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      priority if (q_job_i.pre == PRE_HDR && !hdr_done_q) begin
        byte_d = HEADER_BYTE;
        kind_d = KIND_HDR;
        last_d = 1'b0;
        hdr_done_d = 1'b1;
      end else if (q_job_i.pre == PRE_END) begin
        byte_d = END_BYTE;
        kind_d = KIND_END;
        last_d = 1'b1;
        q_pop_o = 1'b1;
      end else begin
        byte_d = conv_encode(q_job_i.nib, cfg_i.gen_a, cfg_i.gen_b);
        kind_d = KIND_ENC;
        last_d = q_job_i.last;
        hdr_done_d = 1'b0;
        q_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hdr_done_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hdr_done_q <= hdr_done_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    kind_q <= kind_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o = byte_q;
  assign kind_o = kind_q;
  assign last_o = last_q;

endmodule

// File: hw/rtl/packetized_conv_encoder.sv
// top level of the packetized rate 1/2 convolutional encoder
// Input channel: in_valid_i / in_stall_o carry one data byte per beat; the low
// nibble is encoded first, then the high nibble.
// Output channel: out_valid_o / out_stall_i carry one result per beat: a code
// byte (kind 0), a packet header 0x00 (kind 1) or the end marker 0x01 (kind 2);
// last_o marks the final result caused by an input byte.
// Configuration: apb-style port, gen_a at 0x0, gen_b at 0x4, packet_nibbles
// at 0x8, image_bytes at 0xC; write only while the block is idle.
// Result path: the first result of a byte is written into the job queue and then
// into the output register, where it becomes visible.
// Throughput: the front end takes one nibble a cycle while the job queue has
// room, so each byte is held while its high nibble goes; a packet header takes
// an extra output beat, absorbed by the four-entry job queue while output keeps up.
// Stalls: a stalled result holds in the output register; the queue fills and
// then the input stalls. After the end marker later bytes are taken and
// dropped.
// Reset: counters clear, the next byte opens a packet with a header, and the
// registers return to gen_a 7, gen_b 5, packet_nibbles 64, image_bytes 1024.
module packetized_conv_encoder import pce_pkg::*; #(
  parameter int unsigned PACKET_COUNT_BITS = 16,
  parameter int unsigned IMAGE_COUNT_BITS  = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic [1:0]            kind_o,
  output logic                  last_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t cfg;
  logic q_full, q_push, q_valid, q_pop;
  job_t push_job, head_job;

  pce_regs #(
    .IMAGE_COUNT_BITS(IMAGE_COUNT_BITS)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  pce_front #(
    .PACKET_COUNT_BITS(PACKET_COUNT_BITS),
    .IMAGE_COUNT_BITS (IMAGE_COUNT_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .data_byte_i(data_byte_i),
    .cfg_i      (cfg),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (push_job)
  );

  pce_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (push_job),
    .full_o (q_full),
    .valid_o(q_valid),
    .job_o  (head_job),
    .pop_i  (q_pop)
  );

  pce_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_job_i    (head_job),
    .q_pop_o    (q_pop),
    .cfg_i      (cfg),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .kind_o     (kind_o),
    .last_o     (last_o)
  );

endmodule

// File: hw/rtl/pce_checker.sv
// port-level checks of the packetized encoder, bound to the top level
module pce_checker import pce_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic [1:0] kind_o,
  input logic       last_o
);

  logic ended_q;

  // an end marker has been delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && kind_o == KIND_END) begin
      ended_q <= 1'b1;
    end
  end

  // a header is the byte 0x00 and never closes an input's results
  a_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_HDR |-> out_byte_o == HEADER_BYTE && !last_o)
    else $error("header beat malformed");

  // an end marker is the byte 0x01 and always closes an input's results
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_END |-> out_byte_o == END_BYTE && last_o)
    else $error("end beat malformed");

  // nothing follows the end marker
  a_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q |-> !out_valid_o)
    else $error("result after end marker");

  // a header is followed by a code beat
  a_hdr_then_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && kind_o == KIND_HDR |=>
    !out_valid_o || kind_o == KIND_ENC)
    else $error("header not followed by code byte");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(kind_o) && $stable(last_o))
    else $error("stalled result changed");

endmodule

bind packetized_conv_encoder pce_checker u_pce_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_byte_o (out_byte_o),
  .kind_o     (kind_o),
  .last_o     (last_o)
);

// File: tb/sv/packetized_conv_encoder_test.sv
// self-checking testbench of the packetized rate 1/2 convolutional encoder
`timescale 1ns / 1ps

module packetized_conv_encoder_test;
  import pce_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 10;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_BYTES    = 20;
  localparam int WRAP_BYTES     = 8;
  localparam int LONG_BYTES     = 10;
  localparam int CLOSE_BYTES    = 12;

  // one result beat as seen on the output channel
  typedef struct packed {
    logic [7:0] value;
    kind_e      kind;
    logic       last;
  } enc_beat_t;

  // one row of the directed part: a register write or a data beat
  typedef struct packed {
    logic             typed;
    logic [2:0]       n;
    logic             cfg;
    logic [1:0]       ridx;
    logic [31:0]      wval;
    logic [7:0]       data;
    logic [0:3][9:0]  res;
  } plan_row_t;

  // typed results as {byte, kind}; ones code is the all-ones nibble under taps 7 and 5
  localparam logic [9:0] R_HDR  = {HEADER_BYTE, KIND_HDR};
  localparam logic [9:0] R_ZERO = {8'h00, KIND_ENC};
  localparam logic [9:0] R_ONES = {8'hDA, KIND_ENC};
  localparam logic [9:0] R_NONE = '0;
  localparam logic [0:3][9:0] NO_RES = '0;

  localparam int PLAN_LEN = 23;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{1'b1, 3'd3, 1'b0, REG_GEN_A, 32'd0, 8'h00, {R_HDR, R_ZERO, R_ZERO, R_NONE}},
    '{1'b1, 3'd2, 1'b0, REG_GEN_A, 32'd0, 8'hFF, {R_ONES, R_ONES, R_NONE, R_NONE}},
    '{1'b1, 3'd2, 1'b0, REG_GEN_A, 32'd0, 8'h0F, {R_ONES, R_ZERO, R_NONE, R_NONE}},
    '{1'b1, 3'd2, 1'b0, REG_GEN_A, 32'd0, 8'hF0, {R_ZERO, R_ONES, R_NONE, R_NONE}},
    '{1'b0, 3'd0, 1'b0, REG_GEN_A, 32'd0, 8'hA5, NO_RES},
    '{1'b0, 3'd0, 1'b0, REG_GEN_A, 32'd0, 8'h5A, NO_RES},
    '{1'b0, 3'd0, 1'b0, REG_GEN_A, 32'd0, 8'h81, NO_RES},
    '{1'b0, 3'd0, 1'b0, REG_GEN_A, 32'd0, 8'h7E, NO_RES},
    '{1'b0, 3'd0, 1'b1, REG_GEN_A, 32'd0, 8'h00, NO_RES},
    '{1'b0, 3'd0, 1'b1, REG_GEN_B, 32'd0, 8'h00, NO_RES},
    // no taps at all: every code byte is zero
    '{1'b1, 3'd2, 1'b0, REG_GEN_A, 32'd0, 8'hFF, {R_ZERO, R_ZERO, R_NONE, R_NONE}},
    '{1'b1, 3'd2, 1'b0, REG_GEN_A, 32'd0, 8'h00, {R_ZERO, R_ZERO, R_NONE, R_NONE}},
    '{1'b0, 3'd0, 1'b1, REG_GEN_A, 32'd7, 8'h00, NO_RES},
    '{1'b0, 3'd0, 1'b1, REG_GEN_B, 32'd3, 8'h00, NO_RES},
    '{1'b0, 3'd0, 1'b0, REG_GEN_A, 32'd0, 8'h96, NO_RES},
    '{1'b0, 3'd0, 1'b0, REG_GEN_A, 32'd0, 8'h69, NO_RES},
    // 24 nibbles so far: the packet closes after the next low nibble
    '{1'b0, 3'd0, 1'b1, REG_PACKET_NIBBLES, 32'd25, 8'h00, NO_RES},
    '{1'b0, 3'd0, 1'b0, REG_GEN_A, 32'd0, 8'hC3, NO_RES},
    '{1'b0, 3'd0, 1'b0, REG_GEN_A, 32'd0, 8'h3C, NO_RES},
    '{1'b0, 3'd0, 1'b1, REG_GEN_B, 32'd7, 8'h00, NO_RES},
    '{1'b0, 3'd0, 1'b0, REG_GEN_A, 32'd0, 8'h42, NO_RES},
    '{1'b0, 3'd0, 1'b1, REG_IMAGE_BYTES, 32'hFF_FFFF, 8'h00, NO_RES},
    '{1'b0, 3'd0, 1'b0, REG_GEN_A, 32'd0, 8'h24, NO_RES}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            data_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_byte;
  logic [1:0]            kind;
  logic                  last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // predictor copy of registers and state
  logic [2:0]  m_gen_a = 3'd7;
  logic [2:0]  m_gen_b = 3'd5;
  logic [15:0] m_pkt = 16'd64;
  logic [23:0] m_img = 24'd1024;
  phase_e      m_phase = PH_HEADER;
  logic [24:0] m_count = '0;
  logic [15:0] m_fill = '0;

  enc_beat_t due_beats[$];
  enc_beat_t byte_beats[$];
  int        plan_row = -1;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        stall_left = 0;
  bit        idle_on = 1'b1;

  always #(CLK_PERIOD / 2) clk = ~clk;

  packetized_conv_encoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .kind_o      (kind),
    .last_o      (last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // code byte of one nibble, msb first, shift register cleared
  function automatic logic [7:0] code_nibble(input logic [3:0] nib);
    logic       cur;
    logic       p1;
    logic       p2;
    logic [7:0] word;
    p1 = 1'b0;
    p2 = 1'b0;
    word = 8'h00;
    for (int i = 3; i >= 0; i--) begin
      cur = nib[i];
      word = {word[5:0],
              (m_gen_a[2] & cur) ^ (m_gen_a[1] & p1) ^ (m_gen_a[0] & p2),
              (m_gen_b[2] & cur) ^ (m_gen_b[1] & p1) ^ (m_gen_b[0] & p2)};
      p2 = p1;
      p1 = cur;
    end
    return word;
  endfunction

  // frames one data byte into byte_beats and steps the packet state
  function automatic void frame_byte(input logic [7:0] b);
    logic [3:0] nib;
    for (int h = 0; h < 2; h++) begin
      nib = (h == 0) ? b[3:0] : b[7:4];
      if (m_phase == PH_FREE) break;
      if (m_phase == PH_HEADER) begin
        if (m_count < {m_img, 1'b0}) begin
          byte_beats.push_back('{HEADER_BYTE, KIND_HDR, 1'b0});
          m_phase = PH_ENCODE;
        end else begin
          byte_beats.push_back('{END_BYTE, KIND_END, 1'b0});
          m_phase = PH_FREE;
          break;
        end
      end
      byte_beats.push_back('{code_nibble(nib), KIND_ENC, 1'b0});
      if (m_count != '1) m_count = m_count + 1'b1;
      m_fill = m_fill + 1'b1;
      if (m_fill == m_pkt) begin
        m_fill = '0;
        m_phase = PH_HEADER;
      end
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // one data beat, with an optional idle burst ahead of it
  task automatic push_byte(input logic [7:0] b, input int row);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    plan_row <= row;
    do @(posedge clk); while (in_stall);
  endtask

  // wait for every expected beat, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup and access phases, then the bus returns to idle
  task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] val,
                          output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // register write with read-back, mirrored into the predictor
  task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] held;
    logic [31:0] rd;
    settle();
    apb_xfer(1'b1, idx, val, rd);
    case (idx)
      REG_GEN_A: begin
        m_gen_a = val[2:0];
        held = {29'd0, m_gen_a};
      end
      REG_GEN_B: begin
        m_gen_b = val[2:0];
        held = {29'd0, m_gen_b};
      end
      REG_PACKET_NIBBLES: begin
        m_pkt = val[15:0];
        held = {16'd0, m_pkt};
      end
      default: begin
        m_img = val[23:0];
        held = {8'd0, m_img};
      end
    endcase
    apb_xfer(1'b0, idx, 32'd0, rd);
    if (rd !== held)
      flag_mismatch($sformatf("read-back of register %0d: expected %08h, got %08h",
                              idx, held, rd));
  endtask

  // new taps and sizes for a random phase; packets stay short, the image never ends
  task automatic retune();
    set_reg(REG_GEN_A, 32'($urandom_range(0, 7)));
    set_reg(REG_GEN_B, 32'($urandom_range(0, 7)));
    set_reg(REG_PACKET_NIBBLES, 32'(m_fill) + 32'($urandom_range(1, 8)));
    set_reg(REG_IMAGE_BYTES, 32'(m_count[24:1]) + 32'($urandom_range(300, 4000)));
  endtask

  // receiver: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // accepted beats: predict on input, check on output
  always @(posedge clk) begin
    enc_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        byte_beats.delete();
        frame_byte(data_byte);
        if (plan_row >= 0 && PLAN[plan_row].typed) begin
          for (int i = 0; i < int'(PLAN[plan_row].n); i++)
            due_beats.push_back('{PLAN[plan_row].res[i][9:2],
                                  kind_e'(PLAN[plan_row].res[i][1:0]),
                                  i == int'(PLAN[plan_row].n) - 1});
        end else begin
          foreach (byte_beats[i])
            due_beats.push_back('{byte_beats[i].value, byte_beats[i].kind,
                                  i == byte_beats.size() - 1});
        end
      end
      if (out_valid && !out_stall) begin
        if (due_beats.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat: byte %02h kind %0d last %0d",
                                  out_byte, kind, last));
        end else begin
          want = due_beats.pop_front();
          if (out_byte !== want.value || kind !== want.kind || last !== want.last)
            flag_mismatch($sformatf(
              "beat mismatch: expected byte %02h kind %0d last %0d, got byte %02h kind %0d last %0d",
              want.value, want.kind, want.last, out_byte, kind, last));
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog on a channel that has gone quiet
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    for (int r = 0; r < PLAN_LEN; r++) begin
      if (PLAN[r].cfg) set_reg(PLAN[r].ridx, PLAN[r].wval);
      else push_byte(PLAN[r].data, r);
    end

    // random phases with fresh taps and short packets
    for (int p = 0; p < RAND_PHASES; p++) begin
      idle_on = (p % 3 != 2);
      retune();
      repeat (PHASE_BYTES) push_byte(8'($urandom_range(0, 255)), -1);
    end

    // packet size zero: no header while the fill counter climbs
    idle_on = 1'b0;
    set_reg(REG_IMAGE_BYTES, 32'hFF_FFFF);
    set_reg(REG_PACKET_NIBBLES, 32'd0);
    repeat (WRAP_BYTES) push_byte(8'($urandom_range(0, 255)), -1);

    // largest packet size
    set_reg(REG_PACKET_NIBBLES, 32'hFFFF);
    repeat (LONG_BYTES) push_byte(8'($urandom_range(0, 255)), -1);

    // zero image: packet closes after the next low nibble, end marker drops the high one
    set_reg(REG_IMAGE_BYTES, 32'd0);
    set_reg(REG_PACKET_NIBBLES, 32'(m_fill) + 32'd1);
    repeat (CLOSE_BYTES) push_byte(8'($urandom_range(0, 255)), -1);

    in_valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/pce_pkg.sv
hw/rtl/pce_regs.sv
hw/rtl/pce_front.sv
hw/rtl/pce_queue.sv
hw/rtl/pce_back.sv
hw/rtl/packetized_conv_encoder.sv
hw/rtl/pce_checker.sv
tb/sv/packetized_conv_encoder_test.sv
